@@ rtl/ttps_pkg.sv @@
package ttps_pkg;

  localparam int unsigned TABLE_BITS_DEF = 12;
  localparam int unsigned SLOTS_DEF      = 4;

  localparam logic [1:0] BOUND_UPPER = 2'd0;
  localparam logic [1:0] BOUND_LOWER = 2'd1;
  localparam logic [1:0] BOUND_EXACT = 2'd2;

  localparam logic ACT_PROBE = 1'b0;
  localparam logic ACT_STORE = 1'b1;

  typedef struct packed {
    logic        action;
    logic [63:0] signature;
    logic        side;
    logic [7:0]  depth;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic signed [15:0] score;
    logic [15:0] move_code;
    logic        move_is_null;
    logic        null_allowed;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic        cutoff;
    logic        forbid_null;
    logic signed [15:0] entry_score;
    logic [15:0] entry_move;
    logic        entry_move_null;
    logic [7:0]  entry_depth;
    logic [1:0]  entry_bound;
    logic        written;
  } out_item_t;

  // one slot as held in memory
  typedef struct packed {
    logic [63:0] signature;
    logic [7:0]  depth;
    logic [15:0] material;
    logic        side;
    logic [1:0]  bound;
    logic [16:0] move;
    logic [15:0] score;
    logic        null_ok;
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DONE,
    ST_CLEAR
  } state_t;

endpackage

@@ rtl/transposition_table_probe_store_core.sv @@
// a transaction passes through the read state, a walk of the bucket one slot a cycle that
// stops at the picked slot or the last one, and the result and write-back state; busy stays
// high until the return to idle, so no new item is taken before the last one is through
// reset: synchronous active-low rst_n clears root_material, then a clearing pass over all
// 2^TABLE_BITS slots (4096 by default) zeroes every slot while busy stays high
// the receiver cannot stall; each result shows for one cycle on out_valid
module transposition_table_probe_store_core #(
  parameter int unsigned TABLE_BITS = ttps_pkg::TABLE_BITS_DEF,
  parameter int unsigned SLOTS      = ttps_pkg::SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ttps_pkg::in_item_t  in_item,
  output logic                out_valid,
  output ttps_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  ttps_pkg::state_t state_r, state_nxt;
  ttps_pkg::in_item_t item_r;
  logic [15:0] root_r;
  logic [TABLE_BITS-1:0] clr_r, clr_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  logic [TABLE_BITS-1:0] addr_r, raddr;
  logic found_r, found_nxt;
  logic [TABLE_BITS-1:0] vaddr_r, vaddr_nxt;
  ttps_pkg::slot_t vslot_r, vslot_nxt;
  logic vvalid_r, vvalid_nxt;
  ttps_pkg::slot_t rdata, cur, wdata, mem_wdata;
  logic match, pick, last, wr, we, mem_we, clearing;
  logic [TABLE_BITS-1:0] mem_waddr;
  ttps_pkg::out_item_t res;
  logic signed [15:0] val;
  logic cut, eq;

  ttps_slot_mem #(.TABLE_BITS(TABLE_BITS)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata), .raddr(raddr),
    .rdata(rdata)
  );

  assign cur = rdata;

  assign match = (cur.signature == item_r.signature) && (cur.side == item_r.side);
  assign last  = (idx_r == SW'(SLOTS - 1));
  assign pick  = (item_r.action == ttps_pkg::ACT_PROBE)
               ? (match && (item_r.signature != '0))
               : (match || (cur.signature == '0) || (cur.material > root_r) || last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ttps_pkg::ST_CLEAR;
      root_r  <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (cfg_we) begin
        root_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_r <= in_item;
    end
    idx_r    <= idx_nxt;
    addr_r   <= raddr;
    found_r  <= found_nxt;
    vaddr_r  <= vaddr_nxt;
    vslot_r  <= vslot_nxt;
    vvalid_r <= vvalid_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ttps_pkg::ST_IDLE: if (start) state_nxt = ttps_pkg::ST_READ;
      ttps_pkg::ST_READ: state_nxt = ttps_pkg::ST_SCAN;
      ttps_pkg::ST_SCAN: if (pick || last) state_nxt = ttps_pkg::ST_DONE;
      ttps_pkg::ST_DONE: state_nxt = ttps_pkg::ST_IDLE;
      ttps_pkg::ST_CLEAR: if (clr_r == '1) state_nxt = ttps_pkg::ST_IDLE;
      default: state_nxt = ttps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt    = idx_r;
    raddr      = addr_r;
    found_nxt  = found_r;
    vaddr_nxt  = vaddr_r;
    vslot_nxt  = vslot_r;
    vvalid_nxt = vvalid_r;
    clr_nxt    = clr_r;
    unique case (state_r)
      ttps_pkg::ST_IDLE: begin
        idx_nxt   = '0;
        found_nxt = 1'b0;
        raddr     = in_item.signature[TABLE_BITS-1:0];
      end
      ttps_pkg::ST_READ: begin
        raddr = addr_r;
      end
      ttps_pkg::ST_SCAN: begin
        raddr   = addr_r + 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (pick) begin
          found_nxt  = 1'b1;
          vaddr_nxt  = addr_r;
          vslot_nxt  = cur;
          vvalid_nxt = cur.signature != '0;
        end
      end
      ttps_pkg::ST_DONE: ;
      ttps_pkg::ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    val = vslot_r.score;
    cut = 1'b0;
    if (item_r.depth <= vslot_r.depth) begin
      priority if (vslot_r.bound == ttps_pkg::BOUND_EXACT) cut = 1'b1;
      else if (vslot_r.bound == ttps_pkg::BOUND_UPPER) cut = val <= item_r.alpha;
      else cut = val >= item_r.beta;
    end
    eq = item_r.depth == vslot_r.depth;
    priority if (!vvalid_r) wr = 1'b1;
    else if (item_r.depth > vslot_r.depth) wr = 1'b1;
    else if (eq) wr = ((item_r.score > item_r.alpha) && (item_r.score < item_r.beta))
                      || (vslot_r.bound != ttps_pkg::BOUND_EXACT);
    else wr = 1'b0;

    wdata           = '0;
    wdata.signature = item_r.signature;
    wdata.depth     = item_r.depth;
    wdata.material  = root_r;
    wdata.side      = item_r.side;
    wdata.score     = item_r.score;
    wdata.null_ok   = item_r.null_allowed;
    if (item_r.score > item_r.alpha) begin
      wdata.bound = (item_r.score >= item_r.beta) ? ttps_pkg::BOUND_LOWER
                                                  : ttps_pkg::BOUND_EXACT;
      wdata.move  = item_r.move_is_null ? 17'h10000 : {1'b0, item_r.move_code};
    end else begin
      wdata.bound = ttps_pkg::BOUND_UPPER;
      wdata.move  = 17'h10000;
    end

    res = '0;
    if (item_r.action == ttps_pkg::ACT_STORE) begin
      res.written = wr;
    end else if (found_r) begin
      res.hit             = 1'b1;
      res.cutoff          = cut;
      res.forbid_null     = !cut && !vslot_r.null_ok;
      res.entry_score     = vslot_r.score;
      res.entry_move      = vslot_r.move[15:0];
      res.entry_move_null = vslot_r.move[16];
      res.entry_depth     = vslot_r.depth;
      res.entry_bound     = vslot_r.bound;
    end
  end

  assign we        = (state_r == ttps_pkg::ST_DONE) && (item_r.action == ttps_pkg::ACT_STORE)
                   && wr;
  assign clearing  = state_r == ttps_pkg::ST_CLEAR;
  assign mem_we    = we || clearing;
  assign mem_waddr = clearing ? clr_r : vaddr_r;
  assign mem_wdata = clearing ? '0 : wdata;
  assign busy      = state_r != ttps_pkg::ST_IDLE;
  assign out_valid = state_r == ttps_pkg::ST_DONE;
  assign out_item  = res;

  a_write_only_store: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> item_r.action == ttps_pkg::ACT_STORE) else $error("write on probe");
  a_store_finds_victim: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && item_r.action == ttps_pkg::ACT_STORE) |-> found_r)
    else $error("store without victim");
  a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result repeated");
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> (busy && !out_valid)) else $error("transaction during clearing");

endmodule

@@ rtl/ttps_slot_mem.sv @@
module ttps_slot_mem #(
  parameter int unsigned TABLE_BITS = ttps_pkg::TABLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [TABLE_BITS-1:0] waddr,
  input  ttps_pkg::slot_t       wdata,
  input  logic [TABLE_BITS-1:0] raddr,
  output ttps_pkg::slot_t       rdata
);

  ttps_pkg::slot_t mem [0:(1 << TABLE_BITS)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
